// ===== src/ipf_pkg.sv =====
// Shared types, constants and helper functions for the identifier-at-position finder.
// Used by every module of the block and by the channel interfaces; has no dependencies.
package ipf_pkg;

  localparam int LINE_W     = 20;
  localparam int COL_W      = 16;
  localparam int LIMIT_W    = 6;
  localparam int BYTE_W     = 8;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;
  // Wide enough to address a buffer of the largest supported size (64 entries).
  localparam int BUF_ADDR_W = 6;

  localparam logic [BYTE_W-1:0] CHAR_NEWLINE    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [BYTE_W-1:0] CHAR_DIGIT_LO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_DIGIT_HI   = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_LO   = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_HI   = 8'h5A;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_LO   = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_HI   = 8'h7A;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LINE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COLUMN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRUNCATE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COPY_LIMIT    = 2'd3;

  localparam logic [LIMIT_W-1:0] COPY_LIMIT_RESET = 6'd32;

  // One answer for the emitter: found flag and the number of bytes to send.
  typedef struct packed {
    logic               found;
    logic [LIMIT_W-1:0] count;
  } cmd_t;

  // Write port into the identifier buffer.
  typedef struct packed {
    logic                  en;
    logic [BUF_ADDR_W-1:0] addr;
    logic [BYTE_W-1:0]     data;
  } buf_wr_t;

  function automatic logic is_ident(input logic [BYTE_W-1:0] b);
    return (b inside {[CHAR_DIGIT_LO:CHAR_DIGIT_HI], [CHAR_UPPER_LO:CHAR_UPPER_HI],
                      [CHAR_LOWER_LO:CHAR_LOWER_HI], CHAR_UNDERSCORE});
  endfunction

endpackage

// ===== src/ipf_channels.sv =====
// Valid/ready channel interfaces for the text input, result output and register writes.
// Depends on ipf_pkg for field widths.
interface ipf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [ipf_pkg::BYTE_W-1:0]  text_byte;
  modport source (output valid, output kind, output text_byte, input ready);
  modport sink (input valid, input kind, input text_byte, output ready);
endinterface

interface ipf_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic                        has_byte;
  logic [ipf_pkg::BYTE_W-1:0]  id_byte;
  logic                        last;
  modport source (output valid, output found, output has_byte, output id_byte,
                  output last, input ready);
  modport sink (input valid, input found, input has_byte, input id_byte,
                input last, output ready);
endinterface

interface ipf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ipf_pkg::CFG_IDX_W-1:0]   index;
  logic [ipf_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/ipf_front.sv =====
// Front end: holds the registers, walks lines and columns, tracks the identifier run
// and issues one answer command per text. Depends on ipf_pkg and ipf_channels.
module ipf_front #(
  parameter int MAX_IDENT = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  ipf_in_if.sink            in_ch,
  ipf_cfg_if.sink           cfg_ch,
  input  logic              back_idle,
  output logic              push,
  output ipf_pkg::cmd_t     cmd,
  output ipf_pkg::buf_wr_t  buf_wr
);

  localparam int LW = $clog2(MAX_IDENT + 1);

  typedef enum logic [1:0] {PH_SEEK, PH_EXTEND, PH_DONE} phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [ipf_pkg::LINE_W-1:0]    target_line_r, target_line_nxt;
  logic [ipf_pkg::COL_W-1:0]     target_col_r, target_col_nxt;
  logic                          truncate_r, truncate_nxt;
  logic [ipf_pkg::LIMIT_W-1:0]   copy_limit_r, copy_limit_nxt;
  logic [ipf_pkg::LINE_W-1:0]    lines_left_r, lines_left_nxt;
  logic [ipf_pkg::COL_W-1:0]     cols_left_r, cols_left_nxt;
  logic [LW-1:0]                 len_r, len_nxt;

  logic                          in_fire, cfg_fire, rearm, do_track;
  logic                          ident, newline, has_room;
  logic [LW-1:0]                 len_trk;
  logic [6:0]                    lim;
  logic [ipf_pkg::LIMIT_W-1:0]   count_cur, count_trk;

  // A register write takes the cycle; no text item is taken alongside it.
  assign in_ch.ready  = !cfg_ch.valid && ((phase_r == PH_DONE) || back_idle);
  assign cfg_ch.ready = 1'b1;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid;

  assign ident    = ipf_pkg::is_ident(in_ch.text_byte);
  assign newline  = (in_ch.text_byte == ipf_pkg::CHAR_NEWLINE);
  assign has_room = (len_r < LW'(MAX_IDENT));
  assign len_trk  = ident ? (has_room ? LW'(len_r + 1'b1) : len_r) : '0;

  // Bytes actually sent are bounded by both the buffer size and the copy limit.
  assign lim = ({1'b0, copy_limit_r} > 7'(MAX_IDENT)) ? 7'(MAX_IDENT) : {1'b0, copy_limit_r};
  assign count_cur = (7'(len_r) < lim) ? ipf_pkg::LIMIT_W'(len_r) : ipf_pkg::LIMIT_W'(lim);
  assign count_trk = (7'(len_trk) < lim) ? ipf_pkg::LIMIT_W'(len_trk) : ipf_pkg::LIMIT_W'(lim);

  always_comb begin
    phase_nxt       = phase_r;
    target_line_nxt = target_line_r;
    target_col_nxt  = target_col_r;
    truncate_nxt    = truncate_r;
    copy_limit_nxt  = copy_limit_r;
    lines_left_nxt  = lines_left_r;
    cols_left_nxt   = cols_left_r;
    len_nxt         = len_r;
    rearm           = 1'b0;
    do_track        = 1'b0;
    push            = 1'b0;
    cmd             = '0;
    buf_wr          = '0;

    if (cfg_fire) begin
      case (cfg_ch.index)
        ipf_pkg::REG_TARGET_LINE: begin
          target_line_nxt = cfg_ch.data[ipf_pkg::LINE_W-1:0];
          rearm = 1'b1;
        end
        ipf_pkg::REG_TARGET_COLUMN: begin
          target_col_nxt = cfg_ch.data[ipf_pkg::COL_W-1:0];
          rearm = 1'b1;
        end
        ipf_pkg::REG_TRUNCATE: truncate_nxt = cfg_ch.data[0];
        ipf_pkg::REG_COPY_LIMIT: copy_limit_nxt = cfg_ch.data[ipf_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end else if (in_fire) begin
      if (in_ch.kind) begin
        // End of text: answer if still searching or extending, then re-arm.
        if (phase_r == PH_SEEK) begin
          push = 1'b1;
        end else if (phase_r == PH_EXTEND) begin
          push = 1'b1;
          cmd.found = 1'b1;
          cmd.count = count_cur;
        end
        rearm = 1'b1;
      end else begin
        case (phase_r)
          PH_EXTEND: begin
            if (ident) begin
              do_track = 1'b1;
            end else begin
              push = 1'b1;
              cmd.found = 1'b1;
              cmd.count = count_cur;
              phase_nxt = PH_DONE;
            end
          end
          PH_SEEK: begin
            if (lines_left_r != '0) begin
              if (newline) begin
                lines_left_nxt = lines_left_r - 1'b1;
              end
              do_track = 1'b1;
            end else if (cols_left_r != '0) begin
              if (newline) begin
                push = 1'b1;
                phase_nxt = PH_DONE;
              end else begin
                cols_left_nxt = cols_left_r - 1'b1;
                do_track = 1'b1;
              end
            end else if (!ident) begin
              // The target byte is not part of an identifier.
              push = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              do_track = 1'b1;
              if (truncate_r) begin
                push = 1'b1;
                cmd.found = 1'b1;
                cmd.count = count_trk;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_EXTEND;
              end
            end
          end
          default: ;
        endcase
      end
    end

    if (do_track) begin
      len_nxt = len_trk;
      buf_wr.en = ident && has_room;
      buf_wr.addr = ipf_pkg::BUF_ADDR_W'(len_r);
      buf_wr.data = in_ch.text_byte;
    end

    if (rearm) begin
      phase_nxt = PH_SEEK;
      lines_left_nxt = (target_line_nxt == '0) ? '0 : target_line_nxt - 1'b1;
      cols_left_nxt = (target_col_nxt == '0) ? '0 : target_col_nxt - 1'b1;
      len_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SEEK;
      target_line_r <= ipf_pkg::LINE_W'(1);
      target_col_r  <= ipf_pkg::COL_W'(1);
      truncate_r    <= 1'b0;
      copy_limit_r  <= ipf_pkg::COPY_LIMIT_RESET;
      lines_left_r  <= '0;
      cols_left_r   <= '0;
      len_r         <= '0;
    end else begin
      phase_r       <= phase_nxt;
      target_line_r <= target_line_nxt;
      target_col_r  <= target_col_nxt;
      truncate_r    <= truncate_nxt;
      copy_limit_r  <= copy_limit_nxt;
      lines_left_r  <= lines_left_nxt;
      cols_left_r   <= cols_left_nxt;
      len_r         <= len_nxt;
    end
  end

endmodule

// ===== src/ipf_cmd_fifo.sv =====
// Two-entry queue of answer commands between the front end and the emitter.
// Depends on ipf_pkg for the command type.
module ipf_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ipf_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output logic           empty,
  output logic           full,
  output ipf_pkg::cmd_t  head
);

  ipf_pkg::cmd_t  slot_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     fill_r;
  logic           do_push, do_pop;

  assign empty   = (fill_r == 2'd0);
  assign full    = (fill_r == 2'd2);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      fill_r <= fill_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== src/ipf_back.sv =====
// Emitter: owns the identifier buffer and turns each answer command into result items
// through a registered output stage. Depends on ipf_pkg and ipf_channels.
module ipf_back #(
  parameter int MAX_IDENT = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ipf_pkg::buf_wr_t  buf_wr,
  input  logic              cmd_valid,
  input  ipf_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  output logic              idle,
  ipf_out_if.source         out_ch
);

  localparam int AW = (MAX_IDENT > 1) ? $clog2(MAX_IDENT) : 1;

  logic [ipf_pkg::BYTE_W-1:0]   mem [MAX_IDENT];
  logic                         busy_r;
  logic [ipf_pkg::LIMIT_W-1:0]  k_r, n_r;
  logic                         valid_r, found_r, has_byte_r, last_r;
  logic [ipf_pkg::BYTE_W-1:0]   id_byte_r;
  logic                         slot_free, emit, final_byte;

  assign slot_free  = !valid_r || out_ch.ready;
  assign emit       = busy_r && slot_free;
  assign final_byte = (k_r == ipf_pkg::LIMIT_W'(n_r - 1'b1));
  assign cmd_pop    = !busy_r && cmd_valid && ((cmd.count != '0) || slot_free);
  assign idle       = !busy_r && !cmd_valid;

  assign out_ch.valid    = valid_r;
  assign out_ch.found    = found_r;
  assign out_ch.has_byte = has_byte_r;
  assign out_ch.id_byte  = id_byte_r;
  assign out_ch.last     = last_r;

  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      mem[buf_wr.addr[AW-1:0]] <= buf_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (emit) begin
        valid_r    <= 1'b1;
        found_r    <= 1'b1;
        has_byte_r <= 1'b1;
        last_r     <= final_byte;
        id_byte_r  <= mem[k_r[AW-1:0]];
        k_r        <= k_r + 1'b1;
        if (final_byte) begin
          busy_r <= 1'b0;
        end
      end else if (cmd_pop && (cmd.count == '0)) begin
        valid_r    <= 1'b1;
        found_r    <= cmd.found;
        has_byte_r <= 1'b0;
        last_r     <= 1'b1;
        id_byte_r  <= '0;
      end else begin
        if (cmd_pop) begin
          busy_r <= 1'b1;
          k_r    <= '0;
          n_r    <= cmd.count;
        end
        if (slot_free) begin
          valid_r <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== src/identifier_at_position_finder.sv =====
// Identifier-at-position finder: top level joining front end, command queue and emitter.
// Depends on ipf_pkg, ipf_channels, ipf_front, ipf_cmd_fifo and ipf_back.
//
// Usage: a text arrives on in_ch one byte per item (kind 0), closed by an end-of-text
// item (kind 1). Registers on cfg_ch set the one-based target line and column, the
// truncate mode and the copy limit; cfg_ch is always ready and writes take effect at
// once, and in_ch is not ready in a cycle in which a write is offered. A line or
// column write restarts the search at the first byte of a text.
// For each text the block answers once on out_ch: either a single not-found item, a
// single empty found item (copy limit zero), or the identifier holding the target as
// a run of byte items, the final one marked with last.
// Throughput: one text byte per cycle while searching, unless a register write is
// offered or the emitter is still busy. After the item that decides the answer, the
// rest of the text is taken at full rate; the next text waits until the emitter is
// idle, as the emitter reads the identifier buffer that the front end fills.
// The deciding item writes its answer command into the queue. A not-found or empty
// found command goes from the queue straight into the output register; a byte run
// first loads the emitter's counters, then results follow one per cycle from the
// buffer while the receiver takes them.
// When the receiver stalls, the output register holds its item and the emitter waits.
// Reset restores the register defaults (line 1, column 1, no truncation, limit 32)
// and empties the queue and output stage; no clearing pass is needed.
module identifier_at_position_finder #(
  parameter int MAX_IDENT = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ipf_in_if.sink    in_ch,
  ipf_out_if.source out_ch,
  ipf_cfg_if.sink   cfg_ch
);

  logic              push, pop, fifo_empty, fifo_full, back_idle;
  ipf_pkg::cmd_t     push_cmd, head_cmd;
  ipf_pkg::buf_wr_t  buf_wr;

  ipf_front #(.MAX_IDENT(MAX_IDENT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .back_idle (back_idle),
    .push      (push),
    .cmd       (push_cmd),
    .buf_wr    (buf_wr)
  );

  // The front end only answers while the emitter is idle, so the queue never
  // overflows; full is kept for completeness of the queue interface.
  ipf_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push && !fifo_full),
    .push_cmd (push_cmd),
    .pop      (pop),
    .empty    (fifo_empty),
    .full     (fifo_full),
    .head     (head_cmd)
  );

  ipf_back #(.MAX_IDENT(MAX_IDENT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .buf_wr    (buf_wr),
    .cmd_valid (!fifo_empty),
    .cmd       (head_cmd),
    .cmd_pop   (pop),
    .idle      (back_idle),
    .out_ch    (out_ch)
  );

endmodule
